FILE: rtl/core/mts_pkg.sv
// Package for the momentum target smoother: command codes, register indexes,
// fixed-point constants and small arithmetic helpers. No dependencies.
`timescale 1ns / 1ps
package mts_pkg;

  typedef enum logic [2:0] {
    MODE_STEP      = 3'd0,
    MODE_GRAB_TO   = 3'd1,
    MODE_SET_GRAB  = 3'd2,
    MODE_RELEASE   = 3'd3,
    MODE_SET_VALUE = 3'd4,
    MODE_GRAB      = 3'd5
  } mode_e;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRICTION   = 2'd1;

  localparam logic [15:0] SPEED_GAIN_RST = 16'd2560;
  localparam logic [15:0] FRICTION_RST   = 16'd256;

  // 0.2 s in Q0.16, truncated
  localparam logic [15:0] DT_MAX = 16'd13107;
  // ln(2) in Q0.30 and 1.0 in Q1.30
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  // 12.0 in signed Q8.16: log2 of 1/0.0625 scaled back by the 16 fraction bits of P
  localparam logic signed [23:0] LG_BIAS = 24'sd786432;
  localparam logic [3:0] N_TERMS = 4'd10;

  // Reciprocal floor(2^31 / i) for the series divisors
  function automatic logic [31:0] recip31(input logic [3:0] i);
    logic [31:0] r;
    case (i)
      4'd1:    r = 32'd2147483648;
      4'd2:    r = 32'd1073741824;
      4'd3:    r = 32'd715827882;
      4'd4:    r = 32'd536870912;
      4'd5:    r = 32'd429496729;
      4'd6:    r = 32'd357913941;
      4'd7:    r = 32'd306783378;
      4'd8:    r = 32'd268435456;
      4'd9:    r = 32'd238609294;
      4'd10:   r = 32'd214748364;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Saturate a wide signed value to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic fits;
    fits = (&v[65:31]) || !(|v[65:31]);
    if (fits) return v[31:0];
    return v[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

endpackage

FILE: rtl/core/mts_mul.sv
// Shared signed 33x33 multiplier with registered product.
// Depends on nothing.
`timescale 1ns / 1ps
module mts_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] prod_o
);

  logic signed [65:0] prod_q;

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    prod_q <= 66'(a_i * b_i);
  end

  assign prod_o = prod_q;

endmodule

FILE: rtl/core/momentum_target_smoother.sv
// Momentum target smoother, top level: sequencer, state and handshakes.
// Depends on mts_pkg and mts_mul.
`timescale 1ns / 1ps
// Pulls a signed Q16.16 value toward a target with momentum. Each input word
// is a command (grab to target, set and grab, release, set value, start
// grabbing) or a time step of elapsed_time seconds (Q0.16, clamped to 0.2 s);
// every word yields exactly one result word with the value and grab flag.
// A command passes from acceptance through the done state back to idle. For a time
// step all products go through one shared 33x33 multiplier under a sequencer,
// and the steps are the set-up (product, pull, advance), a 5-step normalise,
// 16 squarings for the log2 of speed gain*friction, the exponent, 10 series
// terms of the power (the divide by the term index is a reciprocal multiply
// with a correction), the decay and the hand-over of the result.
// The input is not ready while a word is in work; a finished result waits in
// the output register, so the next word can be taken meanwhile. The config
// port is always ready and must only be written while the block is idle.
module momentum_target_smoother (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [2:0]                      mode_i,
  input  logic signed [31:0]              operand_value_i,
  input  logic [15:0]                     elapsed_time_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [31:0]              current_value_o,
  output logic                            is_grabbed_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mts_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [15:0]                     cfg_data_i
);
  import mts_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_START = 5'd1;
  localparam logic [4:0] S_PLOAD = 5'd2;
  localparam logic [4:0] S_VEL   = 5'd3;
  localparam logic [4:0] S_POSM  = 5'd4;
  localparam logic [4:0] S_POS   = 5'd5;
  localparam logic [4:0] S_NORM  = 5'd6;
  localparam logic [4:0] S_LMUL  = 5'd7;
  localparam logic [4:0] S_LSQ   = 5'd8;
  localparam logic [4:0] S_XMUL  = 5'd9;
  localparam logic [4:0] S_XLD   = 5'd10;
  localparam logic [4:0] S_YLD   = 5'd11;
  localparam logic [4:0] S_TMUL  = 5'd12;
  localparam logic [4:0] S_TRMUL = 5'd13;
  localparam logic [4:0] S_QMUL  = 5'd14;
  localparam logic [4:0] S_TFIX  = 5'd15;
  localparam logic [4:0] S_FMUL  = 5'd16;
  localparam logic [4:0] S_FIN   = 5'd17;
  localparam logic [4:0] S_DONE  = 5'd18;

  logic [4:0] state_q, state_d;

  // configuration and smoother state
  logic [15:0]        speed_gain_q, friction_q;
  logic signed [31:0] position_q, position_d;
  logic signed [31:0] speed_q, speed_d;
  logic signed [31:0] target_q, target_d;
  logic               grab_q, grab_d;

  // working registers of the time step
  logic [13:0]        dt_q, dt_d;
  logic [31:0]        norm_q, norm_d;
  logic [4:0]         exp_q, exp_d;
  logic [15:0]        frac_q, frac_d;
  logic [3:0]         cnt_q, cnt_d;
  logic signed [7:0]  n_q, n_d;
  logic [29:0]        y_q, y_d;
  logic [30:0]        term_q, term_d;
  logic [29:0]        t_q, t_d;
  logic [29:0]        quo_q, quo_d;
  logic [31:0]        sum_q, sum_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] cur_q, cur_d;
  logic               grabbed_q, grabbed_d;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  mts_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  logic               in_acc;
  logic signed [32:0] diff;
  logic signed [23:0] lg;
  logic signed [65:0] pos_sum;
  logic [32:0]        sq;
  logic [33:0]        rem;
  logic               bump;
  logic [30:0]        term_new;
  logic signed [7:0]  shamt_w;
  logic [31:0]        factor;

  assign in_acc      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign diff     = 33'(target_q) - 33'(position_q);
  assign lg       = LG_BIAS - $signed({3'b000, exp_q, frac_q});
  assign pos_sum  = 66'(position_q) + (prod >>> 16);
  assign sq       = prod[63:31];
  assign rem      = {4'b0000, t_q} - prod[33:0];
  assign bump     = (rem >= {30'd0, cnt_q});
  assign term_new = {1'b0, quo_q} + {30'd0, bump};
  assign shamt_w  = 8'sd14 - n_q;
  assign factor   = sum_q >> shamt_w[4:0];

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_START: begin
        mul_a = {17'd0, speed_gain_q};
        mul_b = {17'd0, friction_q};
      end
      S_PLOAD: begin
        mul_a = diff;
        mul_b = {17'd0, speed_gain_q};
      end
      S_POSM: begin
        mul_a = 33'(speed_q);
        mul_b = {19'd0, dt_q};
      end
      S_LMUL: begin
        mul_a = {1'b0, norm_q};
        mul_b = {1'b0, norm_q};
      end
      S_XMUL: begin
        mul_a = 33'(lg);
        mul_b = {19'd0, dt_q};
      end
      S_XLD: begin
        mul_a = {17'd0, prod[31:16]};
        mul_b = {3'd0, LN2_Q30};
      end
      S_TMUL: begin
        mul_a = {2'd0, term_q};
        mul_b = {3'd0, y_q};
      end
      S_TRMUL: begin
        mul_a = {3'd0, prod[59:30]};
        mul_b = {1'b0, recip31(cnt_q)};
      end
      S_QMUL: begin
        mul_a = {3'd0, prod[60:31]};
        mul_b = {29'd0, cnt_q};
      end
      S_FMUL: begin
        mul_a = 33'(speed_q);
        mul_b = {1'b0, factor};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    position_d  = position_q;
    speed_d     = speed_q;
    target_d    = target_q;
    grab_d      = grab_q;
    dt_d        = dt_q;
    norm_d      = norm_q;
    exp_d       = exp_q;
    frac_d      = frac_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    y_d         = y_q;
    term_d      = term_q;
    t_d         = t_q;
    quo_d       = quo_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cur_d       = cur_q;
    grabbed_d   = grabbed_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_DONE;
          case (mode_i)
            MODE_STEP: begin
              state_d = S_START;
              dt_d = (elapsed_time_i > DT_MAX) ? DT_MAX[13:0] : elapsed_time_i[13:0];
            end
            MODE_GRAB_TO: begin
              grab_d   = 1'b1;
              target_d = operand_value_i;
            end
            MODE_SET_GRAB: begin
              grab_d     = 1'b1;
              target_d   = operand_value_i;
              position_d = operand_value_i;
            end
            MODE_RELEASE:   grab_d = 1'b0;
            MODE_SET_VALUE: position_d = operand_value_i;
            MODE_GRAB:      grab_d = 1'b1;
            default: ;
          endcase
        end
      end
      S_START: state_d = S_PLOAD;
      S_PLOAD: begin
        // P = speed gain * friction, a zero product counts as one
        norm_d  = (prod[31:0] == 32'd0) ? 32'd1 : prod[31:0];
        exp_d   = 5'd31;
        cnt_d   = 4'd0;
        state_d = S_VEL;
      end
      S_VEL: begin
        if (grab_q) speed_d = sat32(prod >>> 8);
        state_d = S_POSM;
      end
      S_POSM: state_d = S_POS;
      S_POS: begin
        position_d = sat32(pos_sum);
        state_d    = S_NORM;
      end
      S_NORM: begin
        // binary search for the leading one: 16, 8, 4, 2, 1
        case (cnt_q)
          4'd0: if (norm_q[31:16] == '0) begin
            norm_d = norm_q << 16; exp_d = exp_q - 5'd16;
          end
          4'd1: if (norm_q[31:24] == '0) begin
            norm_d = norm_q << 8;  exp_d = exp_q - 5'd8;
          end
          4'd2: if (norm_q[31:28] == '0) begin
            norm_d = norm_q << 4;  exp_d = exp_q - 5'd4;
          end
          4'd3: if (norm_q[31:30] == '0) begin
            norm_d = norm_q << 2;  exp_d = exp_q - 5'd2;
          end
          default: if (!norm_q[31]) begin
            norm_d = norm_q << 1;  exp_d = exp_q - 5'd1;
          end
        endcase
        if (cnt_q == 4'd4) begin
          cnt_d   = 4'd0;
          frac_d  = '0;
          state_d = S_LMUL;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_LMUL: state_d = S_LSQ;
      S_LSQ: begin
        // square in Q1.31; a carry past 2.0 gives the next fraction bit
        if (sq[32]) begin
          frac_d[4'd15 - cnt_q] = 1'b1;
          norm_d = sq[32:1];
        end else begin
          norm_d = sq[31:0];
        end
        cnt_d   = cnt_q + 4'd1;
        state_d = (cnt_q == 4'd15) ? S_XMUL : S_LMUL;
      end
      S_XMUL: state_d = S_XLD;
      S_XLD: begin
        // exponent x = lg*dt in Q34.32; keep floor(x), its integer part
        n_d     = prod[39:32];
        state_d = S_YLD;
      end
      S_YLD: begin
        y_d     = prod[45:16];
        term_d  = ONE_Q30;
        sum_d   = {1'b0, ONE_Q30};
        cnt_d   = 4'd1;
        state_d = S_TMUL;
      end
      S_TMUL:  state_d = S_TRMUL;
      S_TRMUL: begin
        t_d     = prod[59:30];
        state_d = S_QMUL;
      end
      S_QMUL: begin
        quo_d   = prod[60:31];
        state_d = S_TFIX;
      end
      S_TFIX: begin
        // reciprocal quotient may be one short: correct by the remainder
        term_d = term_new;
        sum_d  = sum_q + {1'b0, term_new};
        if (cnt_q == N_TERMS) begin
          state_d = S_FMUL;
        end else begin
          cnt_d   = cnt_q + 4'd1;
          state_d = S_TMUL;
        end
      end
      S_FMUL: state_d = S_FIN;
      S_FIN: begin
        speed_d = sat32(prod >>> 16);
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          cur_d       = position_q;
          grabbed_d   = grab_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      speed_gain_q <= SPEED_GAIN_RST;
      friction_q   <= FRICTION_RST;
      position_q   <= '0;
      speed_q      <= '0;
      target_q     <= '0;
      grab_q       <= 1'b1;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
    end else begin
      state_q     <= state_d;
      position_q  <= position_d;
      speed_q     <= speed_d;
      target_q    <= target_d;
      grab_q      <= grab_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SPEED_GAIN: speed_gain_q <= cfg_data_i;
          CFG_FRICTION:   friction_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // working and output payload, no reset needed
  always_ff @(posedge clk_i) begin
    dt_q      <= dt_d;
    norm_q    <= norm_d;
    exp_q     <= exp_d;
    frac_q    <= frac_d;
    n_q       <= n_d;
    y_q       <= y_d;
    term_q    <= term_d;
    t_q       <= t_d;
    quo_q     <= quo_d;
    sum_q     <= sum_d;
    cur_q     <= cur_d;
    grabbed_q <= grabbed_d;
  end

  assign out_valid_o     = out_valid_q;
  assign current_value_o = cur_q;
  assign is_grabbed_o    = grabbed_q;

  // mantissa must be normalised before every squaring
  a_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LMUL) |-> norm_q[31])
    else $error("log2 mantissa not normalised");

  // series divisor stays within the reciprocal table
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TFIX) |-> (cnt_q >= 4'd1 && cnt_q <= N_TERMS))
    else $error("series divisor out of range");

  // power exponent integer part stays within the shift range
  a_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FMUL) |-> (n_q >= -8'sd5 && n_q <= 8'sd3))
    else $error("power exponent out of range");

  // a release clears the grab flag at once
  a_rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && mode_i == MODE_RELEASE) |=> !grab_q)
    else $error("release did not clear grab");

endmodule
